### sv/qsc_pkg.sv
package qsc_pkg;

  // Pixel coordinate width of every vertex field.
  localparam int COORD_BITS = 12;

  // Configuration register map.
  localparam int CFG_IDX_W  = 2;
  localparam int CFG_DATA_W = 7;
  localparam logic [CFG_IDX_W-1:0] CFG_ANGLE_TOL = 2'd0;
  localparam logic [CFG_IDX_W-1:0] CFG_SIDE_TOL  = 2'd1;

  localparam int ANG_TOL_W  = 6;
  localparam int SIDE_TOL_W = 7;
  localparam logic [ANG_TOL_W-1:0]  ANG_TOL_RST  = 6'd10;
  localparam logic [SIDE_TOL_W-1:0] SIDE_TOL_RST = 7'd20;

  // CORDIC: angles in 2^-14 degree, 16 micro-rotations.
  localparam int CORDIC_ITERS = 16;
  localparam int ANG_SHIFT    = 14;
  localparam int Z_W          = 25;
  localparam int ANG_W        = 16;  // rounded angle in 1/64 degree
  localparam int DEG180_Z     = 180 * (2 ** ANG_SHIFT);
  localparam int DEG90_Q6     = 5760;
  localparam int DEG270_Q6    = 17280;

  // Square root: length with 8 fraction bits of a squared distance.
  localparam int SQ_ITERS = COORD_BITS + 9;

  // Pipeline depths, counted in register stages from the accepting edge.
  localparam int ANG_LAT  = CORDIC_ITERS + 3;
  localparam int SIDE_LAT = SQ_ITERS + 5;
  localparam int OUT_LAT  = SIDE_LAT + 1;

  typedef struct packed {
    logic [COORD_BITS-1:0] ax;
    logic [COORD_BITS-1:0] ay;
    logic [COORD_BITS-1:0] bx;
    logic [COORD_BITS-1:0] by;
    logic [COORD_BITS-1:0] cx;
    logic [COORD_BITS-1:0] cy;
    logic [COORD_BITS-1:0] dx;
    logic [COORD_BITS-1:0] dy;
  } in_beat_t;

  typedef struct packed {
    logic is_square;
    logic right_angles;
    logic equal_sides;
  } out_beat_t;

  function automatic logic signed [Z_W-1:0] atan_entry(input int i);
    logic signed [Z_W-1:0] v;
    case (i)
      0:       v = 25'sd737280;
      1:       v = 25'sd435242;
      2:       v = 25'sd229970;
      3:       v = 25'sd116736;
      4:       v = 25'sd58595;
      5:       v = 25'sd29326;
      6:       v = 25'sd14667;
      7:       v = 25'sd7334;
      8:       v = 25'sd3667;
      9:       v = 25'sd1833;
      10:      v = 25'sd917;
      11:      v = 25'sd458;
      12:      v = 25'sd229;
      13:      v = 25'sd115;
      14:      v = 25'sd57;
      15:      v = 25'sd29;
      default: v = '0;
    endcase
    return v;
  endfunction

endpackage

### sv/qsc_angle.sv
module qsc_angle (
  input  logic                               clk,
  input  qsc_pkg::in_beat_t                  in_data,
  input  logic [qsc_pkg::ANG_TOL_W-1:0]      ang_tol,
  output logic                               right_r
);

  localparam int CB    = qsc_pkg::COORD_BITS;
  localparam int LANES = 8;
  localparam int N     = qsc_pkg::CORDIC_ITERS;
  localparam int XW    = CB + 3 + qsc_pkg::ANG_SHIFT;
  localparam int ZW    = qsc_pkg::Z_W;
  localparam int AW    = qsc_pkg::ANG_W;
  localparam int DW    = AW + 2;

  logic [CB-1:0] px [LANES];
  logic [CB-1:0] py [LANES];
  logic [CB-1:0] qx [LANES];
  logic [CB-1:0] qy [LANES];

  logic signed [XW-1:0] x_nxt [LANES];
  logic signed [XW-1:0] y_nxt [LANES];
  logic signed [ZW-1:0] z_nxt [LANES];
  logic                 zero_nxt [LANES];

  logic signed [XW-1:0] x_r [N+1][LANES];
  logic signed [XW-1:0] y_r [N+1][LANES];
  logic signed [ZW-1:0] z_r [N+1][LANES];
  logic                 zero_r [N+1][LANES];
  logic signed [AW-1:0] ang_r [LANES];

  // Each corner uses two lanes: vertex minus its two neighbors.
  always_comb begin
    qx[0] = in_data.bx; qy[0] = in_data.by; px[0] = in_data.ax; py[0] = in_data.ay;
    qx[1] = in_data.bx; qy[1] = in_data.by; px[1] = in_data.cx; py[1] = in_data.cy;
    qx[2] = in_data.ax; qy[2] = in_data.ay; px[2] = in_data.bx; py[2] = in_data.by;
    qx[3] = in_data.ax; qy[3] = in_data.ay; px[3] = in_data.dx; py[3] = in_data.dy;
    qx[4] = in_data.dx; qy[4] = in_data.dy; px[4] = in_data.cx; py[4] = in_data.cy;
    qx[5] = in_data.dx; qy[5] = in_data.dy; px[5] = in_data.ax; py[5] = in_data.ay;
    qx[6] = in_data.cx; qy[6] = in_data.cy; px[6] = in_data.bx; py[6] = in_data.by;
    qx[7] = in_data.cx; qy[7] = in_data.cy; px[7] = in_data.dx; py[7] = in_data.dy;
  end

  // Vectors in the left half plane are turned by 180 degrees first.
  always_comb begin
    for (int l = 0; l < LANES; l++) begin
      logic signed [CB:0] ex;
      logic signed [CB:0] ey;
      ex = $signed({1'b0, qx[l]}) - $signed({1'b0, px[l]});
      ey = $signed({1'b0, qy[l]}) - $signed({1'b0, py[l]});
      zero_nxt[l] = (ex == '0) && (ey == '0);
      if (ex < 0) begin
        ex = -ex;
        ey = -ey;
        z_nxt[l] = (ey <= 0) ? ZW'(qsc_pkg::DEG180_Z) : -ZW'(qsc_pkg::DEG180_Z);
      end else begin
        z_nxt[l] = '0;
      end
      x_nxt[l] = XW'(ex) <<< qsc_pkg::ANG_SHIFT;
      y_nxt[l] = XW'(ey) <<< qsc_pkg::ANG_SHIFT;
    end
  end

  always_ff @(posedge clk) begin
    for (int l = 0; l < LANES; l++) begin
      x_r[0][l]    <= x_nxt[l];
      y_r[0][l]    <= y_nxt[l];
      z_r[0][l]    <= z_nxt[l];
      zero_r[0][l] <= zero_nxt[l];
    end
    for (int i = 0; i < N; i++) begin
      for (int l = 0; l < LANES; l++) begin
        zero_r[i+1][l] <= zero_r[i][l];
        if (y_r[i][l] >= 0) begin
          x_r[i+1][l] <= x_r[i][l] + (y_r[i][l] >>> i);
          y_r[i+1][l] <= y_r[i][l] - (x_r[i][l] >>> i);
          z_r[i+1][l] <= z_r[i][l] + qsc_pkg::atan_entry(i);
        end else begin
          x_r[i+1][l] <= x_r[i][l] - (y_r[i][l] >>> i);
          y_r[i+1][l] <= y_r[i][l] + (x_r[i][l] >>> i);
          z_r[i+1][l] <= z_r[i][l] - qsc_pkg::atan_entry(i);
        end
      end
    end
    for (int l = 0; l < LANES; l++) begin
      ang_r[l] <= zero_r[N][l] ? '0 : AW'((z_r[N][l] + ZW'(128)) >>> 8);
    end
  end

  // Corner test on the absolute difference of the two directions.
  logic right_nxt;
  always_comb begin
    logic signed [DW-1:0] d;
    logic signed [DW-1:0] t;
    logic                 ok;
    right_nxt = 1'b1;
    t = DW'({ang_tol, 6'b0});
    for (int c = 0; c < 4; c++) begin
      d = DW'(ang_r[2*c]) - DW'(ang_r[2*c+1]);
      if (d < 0) begin
        d = -d;
      end
      ok = (d == DW'(qsc_pkg::DEG90_Q6)) ||
           ((d > DW'(qsc_pkg::DEG90_Q6) - t) && (d < DW'(qsc_pkg::DEG90_Q6) + t)) ||
           ((d > DW'(qsc_pkg::DEG270_Q6) - t) && (d < DW'(qsc_pkg::DEG270_Q6) + t));
      right_nxt = right_nxt & ok;
    end
  end

  always_ff @(posedge clk) begin
    right_r <= right_nxt;
  end

endmodule

### sv/qsc_side.sv
module qsc_side (
  input  logic                               clk,
  input  logic                               rst_n,
  input  logic                               in_valid,
  input  qsc_pkg::in_beat_t                  in_data,
  input  logic [qsc_pkg::SIDE_TOL_W-1:0]     side_tol,
  output logic                               valid_r,
  output logic                               equal_r
);

  localparam int CB   = qsc_pkg::COORD_BITS;
  localparam int SQ   = qsc_pkg::SQ_ITERS;
  localparam int D2W  = 2 * CB + 1;
  localparam int VW   = 2 * SQ;
  localparam int RW   = SQ + 2;
  localparam int NUMW = SQ + 7;
  localparam int HIW  = SQ + 8;
  localparam int NV   = SQ + 5;

  logic [NV-1:0] v_r;

  // Sides in order AB, AD, BC, CD.
  logic [CB-1:0] ux [4];
  logic [CB-1:0] uy [4];
  logic [CB-1:0] wx [4];
  logic [CB-1:0] wy [4];

  logic [CB-1:0]   adx_r [4];
  logic [CB-1:0]   ady_r [4];
  logic [2*CB-1:0] sqx_r [4];
  logic [2*CB-1:0] sqy_r [4];
  logic [VW-1:0]   rad_r [SQ+1][4];
  logic [RW-1:0]   rem_r [SQ+1][4];
  logic [SQ-1:0]   res_r [SQ+1][4];
  logic [NUMW-1:0] num_r;
  logic [HIW-1:0]  hi_r [3];
  logic [NUMW-1:0] lo_r [3];
  logic            lo_pass_r;
  logic            zero_r;

  always_comb begin
    ux[0] = in_data.ax; uy[0] = in_data.ay; wx[0] = in_data.bx; wy[0] = in_data.by;
    ux[1] = in_data.ax; uy[1] = in_data.ay; wx[1] = in_data.dx; wy[1] = in_data.dy;
    ux[2] = in_data.bx; uy[2] = in_data.by; wx[2] = in_data.cx; wy[2] = in_data.cy;
    ux[3] = in_data.cx; uy[3] = in_data.cy; wx[3] = in_data.dx; wy[3] = in_data.dy;
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v_r <= '0;
    end else begin
      v_r <= {v_r[NV-2:0], in_valid};
    end
  end

  always_ff @(posedge clk) begin
    for (int s = 0; s < 4; s++) begin
      adx_r[s] <= (ux[s] > wx[s]) ? ux[s] - wx[s] : wx[s] - ux[s];
      ady_r[s] <= (uy[s] > wy[s]) ? uy[s] - wy[s] : wy[s] - uy[s];
      sqx_r[s] <= adx_r[s] * adx_r[s];
      sqy_r[s] <= ady_r[s] * ady_r[s];
      rad_r[0][s] <= VW'({D2W'(sqx_r[s]) + D2W'(sqy_r[s]), 16'b0});
      rem_r[0][s] <= '0;
      res_r[0][s] <= '0;
    end
    // One result bit per stage, two radicand bits consumed each time.
    for (int k = 0; k < SQ; k++) begin
      for (int s = 0; s < 4; s++) begin
        logic [RW-1:0] rem_n;
        logic [RW-1:0] trial;
        rem_n = RW'({rem_r[k][s], rad_r[k][s][VW-1 -: 2]});
        trial = RW'({res_r[k][s], 2'b01});
        rad_r[k+1][s] <= rad_r[k][s] << 2;
        if (rem_n >= trial) begin
          rem_r[k+1][s] <= rem_n - trial;
          res_r[k+1][s] <= {res_r[k][s][SQ-2:0], 1'b1};
        end else begin
          rem_r[k+1][s] <= rem_n;
          res_r[k+1][s] <= {res_r[k][s][SQ-2:0], 1'b0};
        end
      end
    end
    num_r     <= NUMW'(res_r[SQ][0]) * NUMW'(7'd100);
    lo_pass_r <= side_tol > 7'd100;
    zero_r    <= (res_r[SQ][0] == '0) || (res_r[SQ][1] == '0) ||
                 (res_r[SQ][2] == '0) || (res_r[SQ][3] == '0);
    for (int j = 0; j < 3; j++) begin
      hi_r[j] <= HIW'(res_r[SQ][j+1]) * HIW'(8'd100 + 8'(side_tol));
      lo_r[j] <= NUMW'(res_r[SQ][j+1]) * NUMW'(7'd100 - side_tol);
    end
  end

  logic equal_nxt;
  always_comb begin
    equal_nxt = !zero_r;
    for (int j = 0; j < 3; j++) begin
      equal_nxt = equal_nxt && (HIW'(num_r) <= hi_r[j]) && (lo_pass_r || (num_r >= lo_r[j]));
    end
  end

  always_ff @(posedge clk) begin
    equal_r <= equal_nxt;
  end

  assign valid_r = v_r[NV-1];

endmodule

### sv/quad_square_classifier_unit.sv
// Square test for a quadrilateral given by its four vertices A, B, C, D.
//
// Input channel: put the eight coordinates on in_data and raise start. The
// beat is taken at a rising edge where start is high and busy is low. busy
// is low at all times outside reset, so a new beat may follow every cycle.
//
// Result channel: out_valid is high for exactly one cycle per input beat,
// with is_square, right_angles and equal_sides on out_data. The receiver
// cannot stall; nothing here ever waits on it, and results come out in the
// order the beats went in.
//
// The result path runs through the square-root pipeline: one stage per
// result bit of the side length, plus the difference, square, radicand,
// ratio product, compare and output stages.
// The CORDIC angle path (16 micro-rotation stages) is shorter and its
// corner result is delayed to line up. Throughput is one beat per cycle.
//
// Configuration: cfg_valid/cfg_ready write the angle tolerance (index 0)
// or the side tolerance (index 1); other indexes are ignored. Write only
// while no beat is in flight. Reset clears all valid bits and loads the
// tolerances with 10 degrees and 20 percent.
module quad_square_classifier_unit (
  input  logic                                clk,
  input  logic                                rst_n,
  input  logic                                start,
  output logic                                busy,
  input  qsc_pkg::in_beat_t                   in_data,
  output logic                                out_valid,
  output qsc_pkg::out_beat_t                  out_data,
  input  logic                                cfg_valid,
  output logic                                cfg_ready,
  input  logic [qsc_pkg::CFG_IDX_W-1:0]       cfg_index,
  input  logic [qsc_pkg::CFG_DATA_W-1:0]      cfg_wdata
);

  localparam int DLY = qsc_pkg::SIDE_LAT - qsc_pkg::ANG_LAT;

  logic                              accept;
  logic [qsc_pkg::ANG_TOL_W-1:0]     ang_tol_r;
  logic [qsc_pkg::SIDE_TOL_W-1:0]    side_tol_r;
  logic                              right;
  logic [DLY-1:0]                    right_dly_r;
  logic                              side_valid;
  logic                              equal;
  logic                              out_valid_r;
  qsc_pkg::out_beat_t                out_data_r;

  // The pipeline never stalls, so the only time a beat is refused is reset.
  assign busy      = !rst_n;
  assign accept    = start && !busy;
  assign cfg_ready = 1'b1;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      ang_tol_r  <= qsc_pkg::ANG_TOL_RST;
      side_tol_r <= qsc_pkg::SIDE_TOL_RST;
    end else if (cfg_valid) begin
      case (cfg_index)
        qsc_pkg::CFG_ANGLE_TOL: ang_tol_r  <= cfg_wdata[qsc_pkg::ANG_TOL_W-1:0];
        qsc_pkg::CFG_SIDE_TOL:  side_tol_r <= cfg_wdata[qsc_pkg::SIDE_TOL_W-1:0];
        default: ;
      endcase
    end
  end

  qsc_angle u_angle (
    .clk     (clk),
    .in_data (in_data),
    .ang_tol (ang_tol_r),
    .right_r (right)
  );

  qsc_side u_side (
    .clk      (clk),
    .rst_n    (rst_n),
    .in_valid (accept),
    .in_data  (in_data),
    .side_tol (side_tol_r),
    .valid_r  (side_valid),
    .equal_r  (equal)
  );

  // Line the corner verdict up with the side verdict of the same beat.
  always_ff @(posedge clk) begin
    right_dly_r <= DLY'({right_dly_r, right});
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else begin
      out_valid_r <= side_valid;
    end
    out_data_r.right_angles <= right_dly_r[DLY-1];
    out_data_r.equal_sides  <= equal;
    out_data_r.is_square    <= right_dly_r[DLY-1] && equal;
  end

  assign out_valid = out_valid_r;
  assign out_data  = out_data_r;

endmodule

### sv/qsc_checker.sv
module qsc_checker (
  input logic               clk,
  input logic               rst_n,
  input logic               start,
  input logic               busy,
  input logic               out_valid,
  input qsc_pkg::out_beat_t out_data
);

  // Every accepted beat yields a result after the fixed latency.
  a_result_follows: assert property (@(posedge clk) disable iff (!rst_n)
    (start && !busy) |-> ##(qsc_pkg::OUT_LAT) out_valid)
    else $error("accepted beat produced no result");

  // No result appears without a beat accepted the fixed latency earlier.
  a_no_spurious: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> $past(start && !busy, qsc_pkg::OUT_LAT))
    else $error("result without a matching input beat");

  // The overall verdict is the conjunction of the two partial verdicts.
  a_verdict: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> (out_data.is_square == (out_data.right_angles && out_data.equal_sides)))
    else $error("is_square disagrees with its parts");

endmodule

bind quad_square_classifier_unit qsc_checker u_qsc_checker (
  .clk       (clk),
  .rst_n     (rst_n),
  .start     (start),
  .busy      (busy),
  .out_valid (out_valid),
  .out_data  (out_data)
);
